// ===== src/q8fa_pkg.sv =====
// Package for the Q8 fixed point to decimal ASCII converter.
// Holds the character codes, range limit and the item types shared by all modules.
// No dependencies.
`default_nettype none

package q8fa_pkg;

    localparam int NUM_CHARS = 6;
    localparam int IDX_W = $clog2(NUM_CHARS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHARS - 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] LIMIT_VALUE = 32'd256000;
    localparam logic [9:0] WHOLE_MAX_ONE = 10'd9;
    localparam logic [9:0] WHOLE_MAX_TWO = 10'd99;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_STAR = 8'h2A;

    typedef logic [NUM_CHARS-1:0][7:0] t_text;

    typedef struct packed {
        logic  ovf;
        t_text text;
    } t_entry;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        digit_char = CH_ZERO + {4'd0, d};
    endfunction

endpackage

`default_nettype wire

// ===== src/q8fa_front.sv =====
// Front end: checks the range of an input value and formats its six characters.
// Integer digits use constant reciprocal multiplies. Depends on q8fa_pkg.
`default_nettype none

module q8fa_front
    import q8fa_pkg::*;
(
    input  wire logic signed [31:0] i_value,
    output t_entry                  o_entry
);

    logic [31:0] u;
    logic [9:0]  whole;
    logic [7:0]  frac;
    logic [17:0] prod10;
    logic [15:0] prod100;
    logic [6:0]  q10;
    logic [3:0]  hund;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic [11:0] frac10;
    logic [14:0] frac100;
    logic [3:0]  tenths;
    logic [6:0]  hcount;
    logic [3:0]  hundredths;
    logic [9:0]  q10_times10;
    logic [6:0]  hund_times10;
    logic [6:0]  tenths_times10;

    always_comb begin
        u       = unsigned'(i_value);
        whole   = u[17:8];
        frac    = u[7:0];

        prod10  = 18'(whole) * 18'd205;
        prod100 = 16'(whole) * 16'd41;
        q10     = prod10[17:11];
        hund    = prod100[15:12];

        q10_times10  = 10'(q10) * 10'd10;
        hund_times10 = 7'(hund) * 7'd10;
        ones = 4'(whole - q10_times10);
        tens = 4'(q10 - hund_times10);

        frac10  = 12'(frac) * 12'd10;
        frac100 = 15'(frac) * 15'd100;
        tenths  = frac10[11:8];
        hcount  = frac100[14:8];
        tenths_times10 = 7'(tenths) * 7'd10;
        hundredths = 4'(hcount - tenths_times10);

        o_entry.ovf = (u >= LIMIT_VALUE);
        if (o_entry.ovf) begin
            o_entry.text[0] = CH_STAR;
            o_entry.text[1] = CH_STAR;
            o_entry.text[2] = CH_STAR;
            o_entry.text[3] = CH_POINT;
            o_entry.text[4] = CH_STAR;
            o_entry.text[5] = CH_STAR;
        end else begin
            o_entry.text[0] = (whole > WHOLE_MAX_TWO) ? digit_char(hund) : CH_SPACE;
            o_entry.text[1] = (whole > WHOLE_MAX_ONE) ? digit_char(tens) : CH_SPACE;
            o_entry.text[2] = digit_char(ones);
            o_entry.text[3] = CH_POINT;
            o_entry.text[4] = digit_char(tenths);
            o_entry.text[5] = digit_char(hundredths);
        end
    end

endmodule

`default_nettype wire

// ===== src/q8fa_queue.sv =====
// Short queue of formatted items between the front end and the character sequencer.
// Depends on q8fa_pkg.
`default_nettype none

module q8fa_queue
    import q8fa_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_not_empty,
    output t_entry      o_head
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic [QPTR_W-1:0]   n_rd_ptr;
    logic [QCNT_W-1:0]   n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_full      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// ===== src/q8fa_back.sv =====
// Back end: steps through the six characters of the queue head into the output register.
// Depends on q8fa_pkg.
`default_nettype none

module q8fa_back
    import q8fa_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_head_valid,
    input  wire t_entry i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_stall,
    output logic [7:0]  o_character,
    output logic        o_last,
    output logic        o_overflow
);

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    logic [7:0]       r_char;
    logic             r_last;
    logic             r_ovf;
    logic             out_free;
    logic             load;
    logic             at_last;

    always_comb begin
        out_free = !r_valid || !i_stall;
        load     = i_head_valid && out_free;
        at_last  = (r_idx == LAST_IDX);
        o_pop    = load && at_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (out_free) begin
                r_valid <= i_head_valid;
            end
            if (load) begin
                r_idx <= at_last ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_head.text[r_idx];
            r_last <= at_last;
            r_ovf  <= i_head.ovf;
        end
    end

    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_overflow  = r_ovf;

endmodule

`default_nettype wire

// ===== src/q8_fixed_point_to_ascii.sv =====
// Top level of the Q8 fixed point to decimal ASCII converter.
// Instantiates q8fa_front, q8fa_queue and q8fa_back; depends on q8fa_pkg.
//
// Usage: an item on the input channel is a 32-bit value read as unsigned
// fixed point with 8 fraction bits. For each item the output channel gives
// six character items: three integer digits right-aligned with spaces, a
// point and two truncated fraction digits. A value that is negative or at
// least 256000 gives the string ***.** with overflow high on all six.
// Last is high on the sixth character.
// Both channels use valid and stall; an item moves on a rising edge with
// valid high and stall low. An accepted item goes into the queue; its
// characters are loaded from the queue head into the output register.
// The output channel carries one character per cycle unless stalled.
// A two-entry queue of formatted items lets a new item be accepted
// while earlier characters are still being sent. When the receiver
// stalls, the output holds and o_stall rises once the queue is full.
// Reset is synchronous and empties the queue and the output register.
`default_nettype none

module q8_fixed_point_to_ascii
    import q8fa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [7:0]              o_character,
    output logic                    o_last,
    output logic                    o_overflow
);

    t_entry front_entry;
    t_entry head_entry;
    logic   q_full;
    logic   q_not_empty;
    logic   q_pop;
    logic   q_push;

    assign o_stall = q_full;
    assign q_push  = i_valid && !q_full;

    q8fa_front u_front (
        .i_value (i_value),
        .o_entry (front_entry)
    );

    q8fa_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_entry     (front_entry),
        .i_pop       (q_pop),
        .o_full      (q_full),
        .o_not_empty (q_not_empty),
        .o_head      (head_entry)
    );

    q8fa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_not_empty),
        .i_head       (head_entry),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_character  (o_character),
        .o_last       (o_last),
        .o_overflow   (o_overflow)
    );

endmodule

`default_nettype wire
